@@ rtl/tsp_pkg.sv @@
`timescale 1ns / 1ps

package tsp_pkg;

  // telnet command and option codes
  localparam logic [7:0] CMD_IAC         = 8'd255;
  localparam logic [7:0] CMD_SB          = 8'd250;
  localparam logic [7:0] CMD_SE          = 8'd240;
  localparam logic [7:0] CMD_GA          = 8'd249;
  localparam logic [7:0] OPT_EXT_OPTIONS = 8'd255;
  localparam logic [7:0] OPT_WIN_SIZE    = 8'd31;

  localparam int SbXoptBeginBytes = 3;
  localparam int SbBeginBytes     = 4;

  // header bytes skipped after the option byte
  localparam logic [2:0] HDR_SKIP_XOPT  = 3'(SbXoptBeginBytes - 3);
  localparam logic [2:0] HDR_SKIP_PLAIN = 3'(SbBeginBytes - 3);

  // result kinds
  localparam logic [2:0] KIND_TEXT    = 3'd0;
  localparam logic [2:0] KIND_CMD     = 3'd1;
  localparam logic [2:0] KIND_GA      = 3'd2;
  localparam logic [2:0] KIND_SUBDATA = 3'd3;
  localparam logic [2:0] KIND_SUBEND  = 3'd4;

  // result queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic [7:0] verb;
    logic [7:0] option;
  } res_t;

  // results of one parsed byte, first result in r0
  typedef struct packed {
    logic r0_valid;
    logic r1_valid;
    res_t r0;
    res_t r1;
  } push_t;

  function automatic res_t mk_res(logic [2:0] kind, logic [7:0] value,
                                  logic [7:0] verb, logic [7:0] option);
    res_t r;
    r.kind   = kind;
    r.value  = value;
    r.verb   = verb;
    r.option = option;
    return r;
  endfunction

endpackage

@@ rtl/tsp_parser.sv @@
`timescale 1ns / 1ps

module tsp_parser (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     rx_byte,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           space_ok,
  output tsp_pkg::push_t push
);

  typedef enum logic [5:0] {
    S_TEXT   = 6'b000001,
    S_IAC    = 6'b000010,
    S_CMD    = 6'b000100,
    S_SBOPT  = 6'b001000,
    S_SBHDR  = 6'b010000,
    S_SBDATA = 6'b100000
  } mode_t;

  // input register
  logic       in_full;
  logic [7:0] in_byte;
  logic       fire;

  mode_t      mode, mode_next;
  logic [7:0] held_verb, held_verb_next;
  logic [7:0] sub_option, sub_option_next;
  logic [2:0] header_count, header_count_next;
  logic [7:0] win0, win0_next;
  logic [7:0] win1, win1_next;
  logic [1:0] window_fill, window_fill_next;
  logic [7:0] inner_verb, inner_verb_next;
  logic [7:0] inner_option, inner_option_next;
  logic [1:0] inner_count, inner_count_next;
  logic       prev_iac, prev_iac_next;

  assign fire     = in_full && space_ok;
  assign in_ready = !in_full || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
    if (in_valid && in_ready) begin
      in_byte <= rx_byte;
    end
  end

  always_comb begin
    logic       se_end;
    logic       ext;
    logic [7:0] old;
    logic [2:0] hc;
    mode_next         = mode;
    held_verb_next    = held_verb;
    sub_option_next   = sub_option;
    header_count_next = header_count;
    win0_next         = win0;
    win1_next         = win1;
    window_fill_next  = window_fill;
    inner_verb_next   = inner_verb;
    inner_option_next = inner_option;
    inner_count_next  = inner_count;
    prev_iac_next     = prev_iac;
    push              = '0;
    se_end = (in_byte == tsp_pkg::CMD_SE) && prev_iac;
    ext    = (sub_option == tsp_pkg::OPT_EXT_OPTIONS);
    old    = win0;
    hc     = 3'd0;

    case (mode)
      S_IAC: begin
        if (in_byte == tsp_pkg::CMD_IAC) begin
          push.r0_valid = 1'b1;
          push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_TEXT, in_byte, 8'd0, 8'd0);
          mode_next = S_TEXT;
        end else if (in_byte == tsp_pkg::CMD_SB) begin
          sub_option_next   = 8'd0;
          header_count_next = 3'd0;
          win0_next         = 8'd0;
          win1_next         = 8'd0;
          window_fill_next  = 2'd0;
          inner_verb_next   = 8'd0;
          inner_option_next = 8'd0;
          inner_count_next  = 2'd0;
          prev_iac_next     = 1'b0;
          mode_next         = S_SBOPT;
        end else if (in_byte == tsp_pkg::CMD_GA) begin
          push.r0_valid = 1'b1;
          push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_GA, 8'd0, 8'd0, 8'd0);
          mode_next = S_TEXT;
        end else begin
          held_verb_next = in_byte;
          mode_next      = S_CMD;
        end
      end
      S_CMD: begin
        push.r0_valid = 1'b1;
        push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_CMD, 8'd0, held_verb, in_byte);
        held_verb_next = 8'd0;
        mode_next      = S_TEXT;
      end
      S_SBOPT: begin
        sub_option_next = in_byte;
        if (in_byte == tsp_pkg::OPT_EXT_OPTIONS || in_byte == tsp_pkg::OPT_WIN_SIZE) begin
          hc = tsp_pkg::HDR_SKIP_XOPT;
        end else begin
          hc = tsp_pkg::HDR_SKIP_PLAIN;
        end
        header_count_next = hc;
        mode_next     = (hc != 3'd0) ? S_SBHDR : S_SBDATA;
        prev_iac_next = (in_byte == tsp_pkg::CMD_IAC);
      end
      S_SBHDR, S_SBDATA: begin
        if (se_end) begin
          // closing IAC SE: flush the byte before the IAC and end the run
          if (ext) begin
            if (inner_count == 2'd1 && window_fill[1]) begin
              push.r0_valid = 1'b1;
              if (inner_verb == tsp_pkg::CMD_SB) begin
                push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_SUBEND, 8'd0, 8'd0, old);
              end else begin
                push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_CMD, 8'd0, inner_verb, old);
              end
            end else if (inner_count[1]) begin
              push.r0_valid = 1'b1;
              if (inner_verb == tsp_pkg::CMD_SB) begin
                push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_SUBEND, 8'd0, 8'd0,
                                          inner_option);
              end else begin
                push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_CMD, 8'd0, inner_verb,
                                          inner_option);
              end
            end
          end else begin
            push.r0_valid = 1'b1;
            if (window_fill[1]) begin
              push.r1_valid = 1'b1;
              push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_SUBDATA, old, 8'd0, sub_option);
              push.r1 = tsp_pkg::mk_res(tsp_pkg::KIND_SUBEND, 8'd0, 8'd0, sub_option);
            end else begin
              push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_SUBEND, 8'd0, 8'd0, sub_option);
            end
          end
          sub_option_next   = 8'd0;
          header_count_next = 3'd0;
          win0_next         = 8'd0;
          win1_next         = 8'd0;
          window_fill_next  = 2'd0;
          inner_verb_next   = 8'd0;
          inner_option_next = 8'd0;
          inner_count_next  = 2'd0;
          prev_iac_next     = 1'b0;
          mode_next         = S_TEXT;
        end else begin
          prev_iac_next = (in_byte == tsp_pkg::CMD_IAC);
          if (mode == S_SBHDR) begin
            header_count_next = header_count - 3'd1;
            if (header_count_next == 3'd0) begin
              mode_next = S_SBDATA;
            end
          end else if (window_fill[1]) begin
            // window full: shift and release the oldest byte
            win0_next = win1;
            win1_next = in_byte;
            if (ext) begin
              if (inner_count == 2'd0) begin
                inner_verb_next  = old;
                inner_count_next = 2'd1;
              end else if (inner_count == 2'd1) begin
                inner_option_next = old;
                inner_count_next  = 2'd2;
              end else if (inner_verb == tsp_pkg::CMD_SB) begin
                push.r0_valid = 1'b1;
                push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_SUBDATA, old, 8'd0,
                                          inner_option);
              end
            end else begin
              push.r0_valid = 1'b1;
              push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_SUBDATA, old, 8'd0, sub_option);
            end
          end else begin
            if (window_fill[0]) begin
              win1_next = in_byte;
            end else begin
              win0_next = in_byte;
            end
            window_fill_next = window_fill + 2'd1;
          end
        end
      end
      default: begin
        if (in_byte == tsp_pkg::CMD_IAC) begin
          mode_next = S_IAC;
        end else begin
          push.r0_valid = 1'b1;
          push.r0 = tsp_pkg::mk_res(tsp_pkg::KIND_TEXT, in_byte, 8'd0, 8'd0);
          mode_next = S_TEXT;
        end
      end
    endcase

    if (!fire) begin
      push = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= S_TEXT;
      held_verb    <= 8'd0;
      sub_option   <= 8'd0;
      header_count <= 3'd0;
      win0         <= 8'd0;
      win1         <= 8'd0;
      window_fill  <= 2'd0;
      inner_verb   <= 8'd0;
      inner_option <= 8'd0;
      inner_count  <= 2'd0;
      prev_iac     <= 1'b0;
    end else if (fire) begin
      mode         <= mode_next;
      held_verb    <= held_verb_next;
      sub_option   <= sub_option_next;
      header_count <= header_count_next;
      win0         <= win0_next;
      win1         <= win1_next;
      window_fill  <= window_fill_next;
      inner_verb   <= inner_verb_next;
      inner_option <= inner_option_next;
      inner_count  <= inner_count_next;
      prev_iac     <= prev_iac_next;
    end
  end

endmodule

@@ rtl/tsp_out_fifo.sv @@
`timescale 1ns / 1ps

module tsp_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  tsp_pkg::push_t      push,
  output logic                space_ok,
  output logic                out_valid,
  input  logic                out_ready,
  output tsp_pkg::res_t       head
);

  tsp_pkg::res_t mem [tsp_pkg::FIFO_DEPTH];

  logic [tsp_pkg::PTR_W-1:0] wr_ptr, rd_ptr;
  logic [tsp_pkg::CNT_W-1:0] count, count_next;
  logic                      pop;
  logic [tsp_pkg::CNT_W-1:0] push_n;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign space_ok  = (count <= tsp_pkg::CNT_W'(tsp_pkg::FIFO_DEPTH - 2));
  assign push_n    = tsp_pkg::CNT_W'(push.r0_valid) + tsp_pkg::CNT_W'(push.r1_valid);
  assign count_next = count + push_n - tsp_pkg::CNT_W'(pop);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.r0_valid) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.r1_valid) begin
      mem[wr_ptr + tsp_pkg::PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + tsp_pkg::PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + tsp_pkg::PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

@@ rtl/telnet_stream_parser_top.sv @@
`timescale 1ns / 1ps
// telnet receive parser: one received byte per transfer on the input channel
// (rx_byte, in_valid, in_ready), zero to two results per byte on the output
// channel (kind, value, verb, option, out_valid, out_ready)
// text bytes, doubled IAC, go-ahead, commands and subnegotiation data/end
// markers come out in stream order
// path: an accepted byte waits in the input register until the result queue
// has room, is parsed from there, and its first result is written into the
// result queue, from whose head it is presented on the output
// throughput: one byte per cycle while the result queue has two free slots; a
// byte that gives two results needs two output transfers, so the four-entry
// result queue absorbs short bursts and then throttles in_ready
// reset (rst, synchronous): parser back in text mode, subnegotiation state
// cleared, input register and result queue emptied
// receiver stall: results wait in the queue; the parse stage only advances
// when two free queue slots exist, and the input register holds one more
// byte before in_ready drops
module telnet_stream_parser_top (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] rx_byte,
  input  logic       in_valid,
  output logic       in_ready,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic [7:0] verb,
  output logic [7:0] option,
  output logic       out_valid,
  input  logic       out_ready
);

  tsp_pkg::push_t push;
  tsp_pkg::res_t  head;
  logic           space_ok;

  // input register plus state machine, writes results into the queue
  tsp_parser u_parser (
    .clk      (clk),
    .rst      (rst),
    .rx_byte  (rx_byte),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .space_ok (space_ok),
    .push     (push)
  );

  // result queue decouples the output handshake from the parser
  tsp_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign kind   = head.kind;
  assign value  = head.value;
  assign verb   = head.verb;
  assign option = head.option;

endmodule
